### src/slc_pkg.sv
// Shared types and constants for the substring matcher with line and column tracking.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slc_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned SRC_W     = 8;
	localparam int unsigned LINE_W    = 20;
	localparam int unsigned COL_W     = 16;
	localparam int unsigned LEN_W     = 5;
	localparam int unsigned CFG_W     = 64;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned PAT_W     = 2 * CFG_W;

	localparam logic [LINE_W-1:0] LINE_MAX     = '1;
	localparam logic [COL_W-1:0]  COL_MAX      = '1;
	localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW    = 2'd0,
		REG_PATTERN_HIGH   = 2'd1,
		REG_PATTERN_LENGTH = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [PAT_W-1:0] pattern;
		logic [LEN_W-1:0] length;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic [SRC_W-1:0]  source_id;
		logic              end_of_file;
	} item_t;

	typedef struct packed {
		logic              hit;
		logic [SRC_W-1:0]  source;
		logic [LINE_W-1:0] line;
		logic [COL_W-1:0]  column;
	} result_t;

endpackage

`default_nettype wire

### src/slc_cfg.sv
// Configuration registers: pattern bytes and pattern length.
// Depends on slc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slc_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write,
	input  wire logic [slc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [slc_pkg::CFG_W-1:0]        cfg_data,
	output slc_pkg::cfg_t                         cfg
);

	logic [slc_pkg::CFG_W-1:0] pat_low_q;
	logic [slc_pkg::CFG_W-1:0] pat_high_q;
	logic [slc_pkg::LEN_W-1:0] pat_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				slc_pkg::REG_PATTERN_LOW: begin
					pat_low_q <= cfg_data;
				end
				slc_pkg::REG_PATTERN_HIGH: begin
					pat_high_q <= cfg_data;
				end
				slc_pkg::REG_PATTERN_LENGTH: begin
					pat_len_q <= cfg_data[slc_pkg::LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.pattern = {pat_high_q, pat_low_q};
	assign cfg.length  = pat_len_q;

endmodule

`default_nettype wire

### src/slc_scan.sv
// Sliding byte window with line/column tags, position counters and parallel pattern compare.
// Depends on slc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slc_scan #(
	parameter int unsigned MAX_PATTERN = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     advance,
	input  slc_pkg::item_t  item,
	input  slc_pkg::cfg_t   cfg,
	output slc_pkg::result_t result
);

	localparam int unsigned FILL_W = $clog2(MAX_PATTERN + 1);
	localparam int unsigned IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [slc_pkg::BYTE_W-1:0] win_byte_q [MAX_PATTERN];
	logic [slc_pkg::LINE_W-1:0] win_line_q [MAX_PATTERN];
	logic [slc_pkg::COL_W-1:0]  win_col_q  [MAX_PATTERN];
	logic [slc_pkg::LINE_W-1:0] line_q;
	logic [slc_pkg::COL_W-1:0]  col_q;
	logic [FILL_W-1:0]          fill_q;

	logic [slc_pkg::BYTE_W-1:0] nb [MAX_PATTERN];
	logic [slc_pkg::LINE_W-1:0] nl [MAX_PATTERN];
	logic [slc_pkg::COL_W-1:0]  nc [MAX_PATTERN];
	logic [slc_pkg::COL_W-1:0]  col_next;
	logic [FILL_W-1:0]          fill_next;
	logic                       len_ok;
	logic                       hit;
	logic [IDX_W-1:0]           first;

	assign col_next  = (col_q < slc_pkg::COL_MAX) ? col_q + 1'b1 : col_q;
	assign fill_next = (fill_q < FILL_W'(MAX_PATTERN)) ? fill_q + 1'b1 : fill_q;

	// window as it stands once the incoming byte is shifted in; index 0 newest
	always_comb begin
		nb[0] = item.text_byte;
		nl[0] = line_q;
		nc[0] = col_next;
		for (int j = 1; j < MAX_PATTERN; j++) begin
			nb[j] = win_byte_q[j-1];
			nl[j] = win_line_q[j-1];
			nc[j] = win_col_q[j-1];
		end
	end

	always_comb begin
		len_ok = (cfg.length != '0) && (32'(cfg.length) <= MAX_PATTERN)
			&& (32'(fill_next) >= 32'(cfg.length));
		first  = IDX_W'(cfg.length - 1'b1);
		hit    = len_ok;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if (32'(k) < 32'(cfg.length)) begin
				if (nb[IDX_W'(cfg.length - 1'b1 - slc_pkg::LEN_W'(k))]
					!= cfg.pattern[k*slc_pkg::BYTE_W +: slc_pkg::BYTE_W]) begin
					hit = 1'b0;
				end
			end
		end
	end

	assign result.hit    = hit;
	assign result.source = item.source_id;
	assign result.line   = nl[first];
	assign result.column = nc[first];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= slc_pkg::LINE_W'(1);
			col_q  <= '0;
			fill_q <= '0;
		end else if (advance) begin
			if (item.end_of_file) begin
				line_q <= slc_pkg::LINE_W'(1);
				col_q  <= '0;
				fill_q <= '0;
			end else begin
				fill_q <= fill_next;
				if (item.text_byte == slc_pkg::NEWLINE_BYTE) begin
					if (line_q < slc_pkg::LINE_MAX) begin
						line_q <= line_q + 1'b1;
					end
					col_q <= '0;
				end else begin
					col_q <= col_next;
				end
			end
		end
	end

	// entries beyond the fill count never affect a hit, so no reset needed
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int j = 0; j < MAX_PATTERN; j++) begin
				win_byte_q[j] <= nb[j];
				win_line_q[j] <= nl[j];
				win_col_q[j]  <= nc[j];
			end
		end
	end

endmodule

`default_nettype wire

### src/substring_match_with_line_column.sv
// A byte taken into the input stage shows its match result from the result register.
// Throughput: one byte per cycle; the window update and compare sit between the
// input stage and the result register, so stalls only come from out_ready.
// Reset (arst_n low, asynchronous): pipeline empty, pattern cleared, line 1, column 0.
// Depends on slc_pkg, slc_cfg and slc_scan.
`timescale 1ns / 1ps
`default_nettype none

module substring_match_with_line_column #(
	parameter int unsigned MAX_PATTERN = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [slc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [slc_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic                           in_valid,
	output      logic                           in_ready,
	input  wire logic [slc_pkg::BYTE_W-1:0]     text_byte,
	input  wire logic [slc_pkg::SRC_W-1:0]      source_id,
	input  wire logic                           end_of_file,
	output      logic                           out_valid,
	input  wire logic                           out_ready,
	output      logic [slc_pkg::SRC_W-1:0]      match_source,
	output      logic [slc_pkg::LINE_W-1:0]     match_line,
	output      logic [slc_pkg::COL_W-1:0]      match_column
);

	slc_pkg::cfg_t    cfg;
	slc_pkg::item_t   item_s1;
	slc_pkg::result_t scan_res;
	slc_pkg::result_t res_s2;
	logic             valid_s1;
	logic             valid_s2;
	logic             s2_free;
	logic             advance;

	slc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	slc_scan #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (scan_res)
	);

	assign s2_free  = !valid_s2 || out_ready;
	assign advance  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= scan_res.hit;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.text_byte   <= text_byte;
			item_s1.source_id   <= source_id;
			item_s1.end_of_file <= end_of_file;
		end
		if (advance) begin
			res_s2 <= scan_res;
		end
	end

	assign out_valid    = valid_s2;
	assign match_source = res_s2.source;
	assign match_line   = res_s2.line;
	assign match_column = res_s2.column;

endmodule

`default_nettype wire

### src/slc_checker.sv
// Port-level checks for the substring matcher, bound to the top level.
// Depends on slc_pkg and substring_match_with_line_column.
`timescale 1ns / 1ps
`default_nettype none

module slc_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [slc_pkg::SRC_W-1:0]   match_source,
	input wire logic [slc_pkg::LINE_W-1:0]  match_line,
	input wire logic [slc_pkg::COL_W-1:0]   match_column
);

	// held result beat keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(match_source)
			&& $stable(match_line) && $stable(match_column))
		else $error("result beat changed while stalled");

	// positions are 1-based
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (match_line != '0) && (match_column != '0))
		else $error("zero line or column in result");

	// empty output register never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind substring_match_with_line_column slc_checker u_slc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.match_source (match_source),
	.match_line   (match_line),
	.match_column (match_column)
);

`default_nettype wire
